// ===== hw/rtl/round_robin_thread_scheduler_defines.svh =====
// Assertion macros for the round-robin thread scheduler.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset only.
`define RRTS_ASSERT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RRTS_ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define RRTS_ASSERT(label, clock, reset_n, prop, msg)

`define RRTS_ASSERT_ALWAYS(label, clock, prop, msg)

`endif

`endif

// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants of the round-robin thread scheduler.
package rrts_pkg;

    localparam int TID_W = 6;
    localparam int CPU_W = 2;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    typedef logic [TID_W-1:0] tid_t;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;

    // Reported new state of the previous thread.
    localparam logic [ST_W-1:0] ST_FREE  = 2'd0;
    localparam logic [ST_W-1:0] ST_READY = 2'd1;
    localparam logic [ST_W-1:0] ST_SLEEP = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CPU_W-1:0] cpu;
        tid_t             thread_id;
        logic             current_dying;
        logic             current_sleeps;
    } in_item_t;

    typedef struct packed {
        logic [CPU_W-1:0] cpu_out;
        tid_t             running_thread;
        logic             ran_idle;
        tid_t             previous_thread;
        logic [ST_W-1:0]  previous_new_state;
        logic             bad_request;
        logic             queue_empty;
    } out_item_t;

    // Operation request to the ready queue.
    typedef struct packed {
        logic enq;
        tid_t enq_id;
        logic deq;
    } q_req_t;

    // Answer of the ready queue for the same cycle.
    typedef struct packed {
        tid_t deq_id;
        logic deq_empty;
        logic empty_after;
    } q_rsp_t;

endpackage

// ===== hw/rtl/rrts_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
interface rrts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rrts_queue.sv =====
// Linked-list FIFO ready queue: head, tail, occupancy and next-link RAM.
module rrts_queue #(
    parameter int MAX_THREADS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rrts_pkg::q_req_t req,
    output rrts_pkg::q_rsp_t rsp
);
    import rrts_pkg::*;

    localparam int LINK_DEPTH = (MAX_THREADS < (1 << TID_W)) ? MAX_THREADS : (1 << TID_W);
    localparam int LAW        = $clog2(LINK_DEPTH);

    tid_t            head_reg;
    tid_t            head_next;
    tid_t            tail_reg;
    tid_t            tail_next;
    logic            nonempty_reg;
    logic            nonempty_next;
    logic            fwd_hit_reg;
    tid_t            fwd_data_reg;
    tid_t            ram_rdata;
    tid_t            head_link;
    tid_t            link_val;
    logic            we;
    logic [LAW-1:0]  waddr;
    logic [LAW-1:0]  raddr;
    tid_t            mid_head;
    tid_t            mid_tail;
    logic            mid_nonempty;

    // The RAM is read every cycle at the head of the next cycle, so
    // head_link always holds the link of the current head. A write to the
    // same entry in that cycle is forwarded around the RAM.
    assign head_link = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign waddr     = tail_reg[LAW-1:0];
    assign raddr     = head_next[LAW-1:0];

    always_comb
    begin
        we           = 1'b0;
        mid_head     = head_reg;
        mid_tail     = tail_reg;
        mid_nonempty = nonempty_reg;
        if (req.enq)
        begin
            if (!nonempty_reg)
            begin
                mid_head = req.enq_id;
                mid_tail = req.enq_id;
            end
            else
            begin
                we       = 1'b1;
                mid_tail = req.enq_id;
            end
            mid_nonempty = 1'b1;
        end

        // A link written in this same cycle is the one a dequeue must follow.
        link_val = (we && (tail_reg == mid_head)) ? req.enq_id : head_link;

        head_next     = mid_head;
        tail_next     = mid_tail;
        nonempty_next = mid_nonempty;
        rsp.deq_id    = '0;
        rsp.deq_empty = 1'b0;
        if (req.deq)
        begin
            if (!mid_nonempty)
            begin
                rsp.deq_empty = 1'b1;
            end
            else
            begin
                rsp.deq_id = mid_head;
                // The list ends at the tail; a head equal to the tail is its last entry.
                if (mid_tail == mid_head)
                begin
                    nonempty_next = 1'b0;
                end
                else
                begin
                    head_next = link_val;
                end
            end
        end
        rsp.empty_after = !nonempty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            fwd_hit_reg  <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= req.enq_id;
    end

    rrts_ram #(
        .WIDTH (TID_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req.enq_id),
        .raddr (raddr),
        .rdata (ram_rdata)
    );
endmodule

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler.
//
// Usage: requests arrive on the req channel and each one produces exactly
// one result transfer on the res channel, in request order. Both channels
// use valid/ready; a transfer happens at a rising edge with both high.
// A request appends a thread to the ready queue, schedules a CPU (disposing
// of its current thread, then taking the queue head or the idle thread),
// marks a CPU finished so it runs the idle thread, or is rejected as bad.
//
// A request is captured in the input register at its transfer. When the
// result register is free or being emptied, its result is registered there
// as the queue and the per-CPU running table are updated, and is offered
// from then on. Throughput is one request per cycle while the receiver
// takes results; the loop that bounds it is the queue head update, whose
// next link comes from a registered RAM read always aimed at the following
// head, with forwarding of a link written in the same cycle.
//
// Reset empties the queue and sets every CPU to the idle thread; no clearing
// pass is needed. When the receiver stalls, the result stays in place, one
// more request can wait in the input register, and req.ready then drops.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = 64,
    parameter int MAX_CPUS    = 4
) (
    input logic  clk,
    input logic  rst_n,
    rrts_stream_if.sink   req,
    rrts_stream_if.source res
);
    import rrts_pkg::*;

`include "round_robin_thread_scheduler_defines.svh"

    // Only CPUs that the request field can name get a running entry.
    localparam int CPU_DEPTH = (MAX_CPUS < (1 << CPU_W)) ? MAX_CPUS : (1 << CPU_W);
    localparam int CIW       = (CPU_DEPTH > 1) ? $clog2(CPU_DEPTH) : 1;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_item_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    out_item_t  res_reg;
    out_item_t  res_item;
    tid_t       running_reg [CPU_DEPTH];

    logic       advance;
    logic       process;
    logic       in_fire;
    logic [CIW-1:0] cidx;
    tid_t       cur;
    logic       cpu_bad;
    logic       tid_bad;
    logic       run_we;
    tid_t       run_val;
    q_req_t     q_req;
    q_rsp_t     q_rsp;

    // The input register moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance   = !res_valid_reg || res.ready;
    assign process   = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign in_fire   = req.valid && req.ready;

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !advance);
    assign res_valid_next = process || (res_valid_reg && !res.ready);

    assign cidx    = s1_item_reg.cpu[CIW-1:0];
    assign cur     = running_reg[cidx];
    assign cpu_bad = (7'(s1_item_reg.cpu) >= 7'(MAX_CPUS));
    assign tid_bad = (s1_item_reg.thread_id == '0)
                     || (11'(s1_item_reg.thread_id) >= 11'(MAX_THREADS));

    // Result and state updates of the item held in the input register.
    // Queue requests are gated by process so the queue only moves when the
    // result is actually captured.
    always_comb
    begin
        q_req                       = '0;
        res_item                    = '0;
        res_item.previous_new_state = ST_NONE;
        run_we                      = 1'b0;
        run_val                     = '0;
        case (s1_item_reg.op) inside
            OP_ADD:
            begin
                if (tid_bad)
                begin
                    res_item.bad_request = 1'b1;
                end
                else
                begin
                    q_req.enq    = process;
                    q_req.enq_id = s1_item_reg.thread_id;
                end
            end
            OP_SCHEDULE, OP_FINISH:
            begin
                res_item.cpu_out = s1_item_reg.cpu;
                if (cpu_bad)
                begin
                    res_item.bad_request = 1'b1;
                end
                else
                begin
                    res_item.previous_thread = cur;
                    run_we                   = 1'b1;
                    if (s1_item_reg.op == OP_SCHEDULE)
                    begin
                        // Dying wins over sleeping; only a runnable,
                        // non-idle thread goes back to the tail.
                        if (s1_item_reg.current_dying)
                        begin
                            res_item.previous_new_state = ST_FREE;
                        end
                        else if (s1_item_reg.current_sleeps)
                        begin
                            res_item.previous_new_state = ST_SLEEP;
                        end
                        else
                        begin
                            res_item.previous_new_state = ST_READY;
                            q_req.enq    = process && (cur != '0);
                            q_req.enq_id = cur;
                        end
                        q_req.deq         = process;
                        run_val           = q_rsp.deq_id;
                        res_item.ran_idle = q_rsp.deq_empty;
                    end
                    res_item.running_thread = run_val;
                end
            end
            default:
            begin
                res_item.bad_request = 1'b1;
            end
        endcase
        res_item.queue_empty = q_rsp.empty_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CPU_DEPTH; i++)
            begin
                running_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (process && run_we)
            begin
                running_reg[cidx] <= run_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= req.data;
        end
        if (process)
        begin
            res_reg <= res_item;
        end
    end

    rrts_queue #(
        .MAX_THREADS (MAX_THREADS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .rsp   (q_rsp)
    );

    // Picking the idle thread means the queue was empty and stays empty.
    `RRTS_ASSERT(a_idle_means_empty, clk, rst_n,
        res_valid_reg && res_reg.ran_idle |-> (res_reg.running_thread == '0)
        && res_reg.queue_empty, "idle pick with non-idle thread or queue")

    // A successful dequeue never hands out the idle thread.
    `RRTS_ASSERT(a_deq_not_idle, clk, rst_n,
        q_req.deq && !q_rsp.deq_empty |-> (q_rsp.deq_id != '0),
        "idle thread dequeued from ready queue")

    // With the result register free the block must take a request.
    `RRTS_ASSERT_ALWAYS(a_ready_when_free, clk,
        !res_valid_reg |-> req.ready, "request blocked with free result slot")
endmodule

// ===== sim/tb_round_robin_thread_scheduler.sv =====
// Self-checking testbench for the round-robin thread scheduler.
module tb_round_robin_thread_scheduler;
    import rrts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_THREADS = 64;
    localparam int MAX_CPUS    = 4;

    // The package names three operations; the fourth encoding is rejected by the block.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // A transfer on either channel resets this count. The longest quiet stretch
    // in a correct run is the receiver hold-off.
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Settling time after the last result, with margin.
    localparam int SETTLE_CYCLES  = 8;

    logic clk;
    logic rst_n;

    rrts_stream_if #(.payload_t(in_item_t))  req_ch ();
    rrts_stream_if #(.payload_t(out_item_t)) res_ch ();

    round_robin_thread_scheduler #(
        .MAX_THREADS (MAX_THREADS),
        .MAX_CPUS    (MAX_CPUS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Scheduler state as this testbench expects it to be. The ready queue
    // is a singly linked list through ready_link, with ready_link_end
    // marking the last entry of each chain.
    // ------------------------------------------------------------------
    tid_t ready_link     [MAX_THREADS];
    bit   ready_link_end [MAX_THREADS];
    tid_t ready_head;
    tid_t ready_tail;
    bit   ready_nonempty;
    tid_t cpu_thread     [MAX_CPUS];

    // Results the block still owes us, oldest first.
    out_item_t pending_results[$];

    // Knobs shared between the tests, the request tasks and the result sink.
    bit tx_idling;
    bit rx_idling;
    int rx_hold_request;

    // Bookkeeping for the run summary.
    int mismatches;
    int results_checked;
    int n_adds;
    int n_schedules;
    int n_finishes;
    int n_unknown;
    int n_rejected;
    int n_idle_picks;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Expected behavior.
    // ------------------------------------------------------------------
    function automatic void clear_expected_state();
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            ready_link[i]     = '0;
            ready_link_end[i] = 1'b1;
        end
        for (int c = 0; c < MAX_CPUS; c++)
            cpu_thread[c] = '0;
        ready_head     = '0;
        ready_tail     = '0;
        ready_nonempty = 1'b0;
    endfunction

    // Append to the tail. A thread that is already queued is linked again
    // without any check; the hardware does not check either.
    function automatic void ready_append(tid_t t);
        if (!ready_nonempty)
        begin
            ready_head     = t;
            ready_tail     = t;
            ready_nonempty = 1'b1;
        end
        else
        begin
            ready_link[ready_tail]     = t;
            ready_link_end[ready_tail] = 1'b0;
            ready_tail                 = t;
        end
        ready_link_end[t] = 1'b1;
    endfunction

    // Pop the head, or hand back the idle thread when nothing is queued.
    // The queue ends when the head reaches the tail or its link is marked
    // as the end of a chain.
    function automatic tid_t ready_take(output bit was_empty);
        tid_t t;
        t = ready_head;
        if (!ready_nonempty)
        begin
            was_empty = 1'b1;
            return '0;
        end
        was_empty = 1'b0;
        if (ready_tail == t || ready_link_end[t])
            ready_nonempty = 1'b0;
        else
            ready_head = ready_link[t];
        return t;
    endfunction

    function automatic out_item_t predict_dispatch(in_item_t rq);
        out_item_t r;
        tid_t      cur;
        bit        empty;
        r = '0;
        r.previous_new_state = ST_NONE;
        case (rq.op)
            OP_ADD:
            begin
                if (rq.thread_id == '0)
                    r.bad_request = 1'b1;
                else
                    ready_append(rq.thread_id);
            end
            OP_SCHEDULE, OP_FINISH:
            begin
                r.cpu_out         = rq.cpu;
                cur               = cpu_thread[rq.cpu];
                r.previous_thread = cur;
                if (rq.op == OP_FINISH)
                begin
                    cpu_thread[rq.cpu] = '0;
                end
                else
                begin
                    // Dying wins over sleeping; the idle thread is reported
                    // as ready but never goes back on the queue.
                    if (rq.current_dying)
                        r.previous_new_state = ST_FREE;
                    else if (rq.current_sleeps)
                        r.previous_new_state = ST_SLEEP;
                    else
                    begin
                        if (cur != '0)
                            ready_append(cur);
                        r.previous_new_state = ST_READY;
                    end
                    cpu_thread[rq.cpu] = ready_take(empty);
                    r.ran_idle         = empty;
                end
                r.running_thread = cpu_thread[rq.cpu];
            end
            default:
                r.bad_request = 1'b1;
        endcase
        r.queue_empty = !ready_nonempty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request source.
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic in_item_t make_request(logic [OP_W-1:0] op, int cpu, int tid,
                                              bit dying, bit sleeps);
        in_item_t rq;
        rq.op             = op;
        rq.cpu            = cpu[CPU_W-1:0];
        rq.thread_id      = tid[TID_W-1:0];
        rq.current_dying  = dying;
        rq.current_sleeps = sleeps;
        return rq;
    endfunction

    // Draw a request with the given percentages of add, schedule and finish;
    // whatever is left over goes to the rejected encoding.
    function automatic in_item_t random_request(int add_pct, int sched_pct, int finish_pct);
        in_item_t rq;
        int       pick;
        pick              = $urandom_range(0, 99);
        rq.cpu            = CPU_W'($urandom_range(0, MAX_CPUS - 1));
        rq.thread_id      = TID_W'($urandom_range(0, MAX_THREADS - 1));
        rq.current_dying  = ($urandom_range(0, 3) == 0);
        rq.current_sleeps = ($urandom_range(0, 3) == 0);
        if (pick < add_pct)
            rq.op = OP_ADD;
        else if (pick < add_pct + sched_pct)
            rq.op = OP_SCHEDULE;
        else if (pick < add_pct + sched_pct + finish_pct)
            rq.op = OP_FINISH;
        else
            rq.op = OP_UNKNOWN;
        return rq;
    endfunction

    // Offer one request and return at the edge where it transfers. Valid is
    // left high so that a follow-on request can go out in the very next
    // cycle; a gap, if one is drawn, lowers it first. Callers that stop
    // sending call stop_sending.
    task automatic send_request(input in_item_t rq);
        out_item_t want;
        int        gap;
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        want = predict_dispatch(rq);
        pending_results.push_back(want);
        case (rq.op)
            OP_ADD:      n_adds++;
            OP_SCHEDULE: n_schedules++;
            OP_FINISH:   n_finishes++;
            default:     n_unknown++;
        endcase
        if (want.bad_request)
            n_rejected++;
        if (want.ran_idle)
            n_idle_picks++;
        if (tx_idling && $urandom_range(0, 9) < 3)
        begin
            gap = pick_idle_gap();
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-picked sequence: the idle add, all four CPUs, both flags alone
    // and together, the idle thread as current, a duplicate add, an empty
    // queue on schedule, finish, and the rejected encoding. Thread ids 63,
    // 42 and 21 toggle every bit of the id field both ways.
    task automatic test_directed();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        send_request(make_request(OP_ADD,      0,  0, 0, 0));
        send_request(make_request(OP_SCHEDULE, 0,  0, 0, 0));
        send_request(make_request(OP_ADD,      0, 63, 0, 0));
        send_request(make_request(OP_ADD,      0,  1, 0, 0));
        send_request(make_request(OP_ADD,      0, 42, 0, 0));
        send_request(make_request(OP_ADD,      0, 21, 0, 0));
        send_request(make_request(OP_SCHEDULE, 3,  0, 0, 0));
        send_request(make_request(OP_SCHEDULE, 3,  0, 1, 1));
        send_request(make_request(OP_SCHEDULE, 1,  0, 0, 1));
        send_request(make_request(OP_SCHEDULE, 2,  0, 1, 0));
        send_request(make_request(OP_SCHEDULE, 1, 63, 0, 0));
        send_request(make_request(OP_ADD,      0,  5, 0, 0));
        send_request(make_request(OP_ADD,      0,  5, 0, 0));
        send_request(make_request(OP_SCHEDULE, 0,  0, 0, 0));
        send_request(make_request(OP_FINISH,   3,  0, 0, 0));
        send_request(make_request(OP_FINISH,   0, 63, 1, 1));
        send_request(make_request(OP_UNKNOWN,  3, 63, 1, 1));
        send_request(make_request(OP_SCHEDULE, 3,  0, 0, 1));
        send_request(make_request(OP_SCHEDULE, 2,  0, 1, 0));
        send_request(make_request(OP_ADD,      0, 63, 0, 0));
        send_request(make_request(OP_SCHEDULE, 1,  0, 0, 0));
        send_request(make_request(OP_SCHEDULE, 1,  0, 0, 0));
        send_request(make_request(OP_SCHEDULE, 0,  0, 0, 0));
        stop_sending();
    endtask

    // Mixed traffic with random gaps on both sides; every fifty requests a
    // stretch of ten runs with no idling at all.
    task automatic test_random_mixed(int count);
        for (int i = 0; i < count; i++)
        begin
            tx_idling = (i % 50) < 40;
            rx_idling = (i % 50) < 40;
            send_request(random_request(40, 40, 15));
        end
        stop_sending();
    endtask

    // Build a deep queue with mostly adds, then drain it with mostly
    // schedules so that the empty-queue and idle-pick paths get exercised.
    task automatic test_queue_fill_and_drain(int count);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(random_request(80, 15, 3));
        for (int i = 0; i < count; i++)
            send_request(random_request(5, 85, 10));
        stop_sending();
    endtask

    // Back-to-back traffic at full rate on both channels.
    task automatic test_full_rate(int count);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        for (int i = 0; i < count; i++)
            send_request(random_request(45, 45, 8));
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills up and drops req.ready until results drain.
    task automatic test_result_backpressure(int count);
        tx_idling       = 1'b0;
        rx_idling       = 1'b0;
        rx_hold_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < count; i++)
            send_request(random_request(45, 45, 8));
        stop_sending();
    endtask

    // The sender stops and waits for every outstanding result before it
    // carries on, so the block goes fully idle mid-run.
    task automatic test_pause_until_drained(int count);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(random_request(45, 40, 10));
        stop_sending();
        wait_results_drained();
        for (int i = 0; i < count; i++)
            send_request(random_request(45, 40, 10));
        stop_sending();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid    <= 1'b0;
        req_ch.data     <= '0;
        rst_n           <= 1'b0;
        tx_idling       = 1'b0;
        rx_idling       = 1'b0;
        rx_hold_request = 0;
        mismatches      = 0;
        results_checked = 0;
        n_adds          = 0;
        n_schedules     = 0;
        n_finishes      = 0;
        n_unknown       = 0;
        n_rejected      = 0;
        n_idle_picks    = 0;
        clear_expected_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mixed(200);
        test_queue_fill_and_drain(80);
        test_full_rate(60);
        test_result_backpressure(24);
        test_pause_until_drained(30);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d adds, %0d schedules (%0d idle picks),",
                 n_adds + n_schedules + n_finishes + n_unknown,
                 n_adds, n_schedules, n_idle_picks);
        $display("%0d finishes, %0d unknown ops, %0d rejected; %0d results, %0d mismatches.",
                 n_finishes, n_unknown, n_rejected, results_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink. Ready follows a gap counter: a requested hold-off loads
    // it once, and while idling is on the counter is reloaded at random.
    // ------------------------------------------------------------------
    initial
    begin
        int gap_left;
        gap_left = 0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                gap_left        = rx_hold_request;
                rx_hold_request = 0;
            end
            if (gap_left > 0)
            begin
                res_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (rx_idling && $urandom_range(0, 9) < 3)
                    gap_left = pick_idle_gap();
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer is matched against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        out_item_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, got %p", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("cpu_out", 32'(want.cpu_out), 32'(got.cpu_out));
                check_field("running_thread", 32'(want.running_thread),
                            32'(got.running_thread));
                check_field("ran_idle", 32'(want.ran_idle), 32'(got.ran_idle));
                check_field("previous_thread", 32'(want.previous_thread),
                            32'(got.previous_thread));
                check_field("previous_new_state", 32'(want.previous_new_state),
                            32'(got.previous_new_state));
                check_field("bad_request", 32'(want.bad_request), 32'(got.bad_request));
                check_field("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long.
    // ------------------------------------------------------------------
    initial quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
